/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the duty ramp block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a clocked property with reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Implication check: the consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/mcdr_pkg.sv */
// Package with constants and result types of the motor command duty ramp.
package mcdr_pkg;

    localparam int MOTOR_COUNT   = 2;
    localparam int PIN_W         = 2;
    localparam int DUTY_W        = 10;
    localparam int SPEED_W       = 7;
    localparam int INTERVAL_W    = 16;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 24;

    localparam logic [DUTY_W-1:0]     DUTY_FULL      = 10'd999;
    localparam logic [SPEED_W-1:0]    SPEED_FULL     = 7'd100;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'hFCF;

    // Enable and direction mode codes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;
    localparam logic [1:0] MODE_KEEP   = 2'd3;

    // Operation codes carried in tuser
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_readback;
        logic               ramp_busy;
        logic [DUTY_W-1:0]  duty_compare;
        logic [PIN_W-1:0]   direction_pins;
        logic [PIN_W-1:0]   enable_pins;
    } t_result;

    function automatic logic [PIN_W-1:0] apply_mode(
        input logic [PIN_W-1:0] bits,
        input logic [1:0]       mode,
        input logic [PIN_W-1:0] mask
    );
        logic [PIN_W-1:0] res;
        case (mode)
            MODE_CLEAR:  res = bits & ~mask;
            MODE_SET:    res = bits | mask;
            MODE_TOGGLE: res = bits ^ mask;
            default:     res = bits;
        endcase
        return res;
    endfunction

endpackage

/* hdl/motor_command_duty_ramp.sv */
// Motor command decoder and shared PWM duty ramp with a skid-buffered result stream.
//
// Usage:
//   Slave stream carries one transaction per command or tick. tuser[0] is the
//   operation (0 command, 1 tick); tdata holds motor_select, enable_mode,
//   direction_mode and speed_percent. Every accepted transaction produces one
//   result transaction on the master stream with pins, duty, busy flag and
//   percent readback reflecting the state after that item.
//   Configuration: a single write port sets ramp_interval (ticks per duty
//   step); write it only while the stream is idle.
// Timing:
//   The result is registered in the output or skid register. One item is
//   accepted per clock while the skid register is empty; the state update and
//   result are formed in a single combinational pass ahead of the result register.
//   When the receiver stalls, a skid register takes one more result; the
//   slave tready drops only while that skid register is full.
// Reset:
//   Synchronous active-low reset clears enable/direction bits, duty, target
//   and tick counter, empties the output stage and sets ramp_interval to 4047.
module motor_command_duty_ramp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port (ramp_interval)
    input  logic                            i_cfg_wr_en,
    input  logic [mcdr_pkg::INTERVAL_W-1:0] i_cfg_wr_data,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] motor_select, [2:1] enable_mode, [4:3] direction_mode,
    // [11:5] speed_percent, [15:12] zero
    input  logic [mcdr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                            s_axis_tuser,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] enable_pins, [3:2] direction_pins, [13:4] duty_compare,
    // [14] ramp_busy, [21:15] speed_readback, [23:22] zero
    output logic [mcdr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mcdr_pkg::*;

    `include "assert_macros.svh"

    // State registers
    logic [INTERVAL_W-1:0] r_ramp_interval;
    logic [PIN_W-1:0]      r_enable, n_enable;
    logic [PIN_W-1:0]      r_direction, n_direction;
    logic [DUTY_W-1:0]     r_duty, n_duty;
    logic [DUTY_W-1:0]     r_target, n_target;
    logic [INTERVAL_W-1:0] r_tick_count, n_tick_count;

    // Output stage
    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    t_result n_result;

    logic                  w_accept;
    logic                  w_op;
    logic                  w_motor;
    logic [1:0]            w_en_mode;
    logic [1:0]            w_dir_mode;
    logic [SPEED_W-1:0]    w_speed;
    logic [PIN_W-1:0]      w_mask;
    logic [INTERVAL_W-1:0] w_limit;
    logic [DUTY_W-1:0]     w_duty_inc;
    logic [DUTY_W+8-1:0]   w_product;
    logic [SPEED_W-1:0]    w_readback;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_op       = s_axis_tuser;
    assign w_motor    = s_axis_tdata[0];
    assign w_en_mode  = s_axis_tdata[2:1];
    assign w_dir_mode = s_axis_tdata[4:3];
    assign w_speed    = s_axis_tdata[11:5];

    assign s_axis_tready = !r_skid_valid;

    // Motor mask: motors beyond the count leave the pins alone
    always_comb begin
        if (32'(w_motor) < MOTOR_COUNT) begin
            w_mask = PIN_W'(1) << w_motor;
        end else begin
            w_mask = '0;
        end
    end

    assign w_limit = (r_ramp_interval == '0) ? INTERVAL_W'(1) : r_ramp_interval;

    // Next state for one command or tick
    always_comb begin
        n_enable     = r_enable;
        n_direction  = r_direction;
        n_duty       = r_duty;
        n_target     = r_target;
        n_tick_count = r_tick_count;
        if (w_op == OP_COMMAND) begin
            n_enable    = apply_mode(r_enable, w_en_mode, w_mask);
            n_direction = apply_mode(r_direction, w_dir_mode, w_mask);
            if (w_speed == '0) begin
                n_enable = n_enable & ~w_mask;
                n_target = '0;
            end else if (w_speed == SPEED_FULL) begin
                n_target = DUTY_FULL;
            end else if (w_speed < SPEED_FULL) begin
                // speed*10-1 = speed*8 + speed*2 - 1
                n_target = (DUTY_W'(w_speed) << 3) + (DUTY_W'(w_speed) << 1) - DUTY_W'(1);
            end
        end else begin
            if (r_duty == r_target) begin
                n_tick_count = '0;
            end else if ({1'b0, r_tick_count} + 17'd1 >= {1'b0, w_limit}) begin
                n_tick_count = '0;
                if (r_duty < r_target) begin
                    n_duty = r_duty + DUTY_W'(1);
                end else begin
                    n_duty = r_duty - DUTY_W'(1);
                end
            end else begin
                n_tick_count = r_tick_count + INTERVAL_W'(1);
            end
        end
    end

    // Percent readback: (duty+1)/10 via reciprocal 205/2048, exact below 1029
    assign w_duty_inc = n_duty + DUTY_W'(1);
    assign w_product  = 18'(w_duty_inc) * 18'd205;

    always_comb begin
        if (n_duty == '0 || n_duty == DUTY_W'(1)) begin
            w_readback = '0;
        end else if (n_duty >= DUTY_FULL) begin
            w_readback = SPEED_FULL;
        end else begin
            w_readback = w_product[11+SPEED_W-1:11];
        end
    end

    always_comb begin
        n_result.enable_pins    = n_enable;
        n_result.direction_pins = n_direction;
        n_result.duty_compare   = n_duty;
        n_result.ramp_busy      = (n_duty != n_target);
        n_result.speed_readback = w_readback;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_interval <= INTERVAL_RESET;
        end else if (i_cfg_wr_en) begin
            r_ramp_interval <= i_cfg_wr_data;
        end
    end

    // State update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= '0;
            r_direction  <= '0;
            r_duty       <= '0;
            r_target     <= '0;
            r_tick_count <= '0;
        end else if (w_accept) begin
            r_enable     <= n_enable;
            r_direction  <= n_direction;
            r_duty       <= n_duty;
            r_target     <= n_target;
            r_tick_count <= n_tick_count;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= n_result;
            end
        end else if (w_accept) begin
            r_skid_data <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-$bits(t_result)){1'b0}}, r_out_data};

    // Assertions
    `ASSERT_CLK(a_skid_implies_out, i_clk, i_rst_n,
        (!r_skid_valid || r_out_valid), "skid holds data while output stage is empty")
    `ASSERT_CLK(a_duty_range, i_clk, i_rst_n,
        (!r_out_valid || r_out_data.duty_compare <= DUTY_FULL), "duty beyond full scale")
    `ASSERT_NEXT(a_idle_tick_clears, i_clk, i_rst_n,
        (w_accept && w_op == OP_TICK && r_duty == r_target),
        (r_tick_count == '0), "idle tick did not clear the tick counter")
    `ASSERT_CLK(a_duty_single_step, i_clk, i_rst_n,
        (!$past(i_rst_n) || r_duty == $past(r_duty) ||
         r_duty == $past(r_duty) + DUTY_W'(1) || r_duty + DUTY_W'(1) == $past(r_duty)),
        "duty moved by more than one step")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the motor command decoder and duty ramp block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcdr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    typedef enum logic {ACT_ITEM, ACT_CFG} t_stim_kind;

    typedef struct {
        t_stim_kind              kind;
        logic                    op;
        logic [IN_DATA_W-1:0]    word;
        logic [INTERVAL_W-1:0]   interval;
    } t_stim_action;

    // DUT connections
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [INTERVAL_W-1:0]   i_cfg_wr_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    // Predicted block state
    logic [PIN_W-1:0]        en_bits = '0;
    logic [PIN_W-1:0]        dir_bits = '0;
    logic [DUTY_W-1:0]       duty_now = '0;
    logic [DUTY_W-1:0]       duty_goal = '0;
    logic [INTERVAL_W-1:0]   tick_cnt = '0;
    logic [INTERVAL_W-1:0]   ramp_len = INTERVAL_RESET;

    t_stim_action            stim_q[$];
    t_result                 pending_results[$];

    int   error_count = 0;
    int   cycle_cnt = 0;
    bit   cmd_taken = 1'b0;
    bit   stim_done = 1'b0;
    int   burst_left = 4;
    int   gap_left = 0;
    int   ready_mode = 0;
    int   ready_span = 0;

    motor_command_duty_ramp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Clear / set / toggle / keep on the pins picked by mask
    function automatic logic [PIN_W-1:0] next_pins(input logic [PIN_W-1:0] pins,
                                                  input logic [1:0] mode,
                                                  input logic [PIN_W-1:0] mask);
        logic [PIN_W-1:0] res;
        res = pins;
        if (mode == MODE_CLEAR) res = pins & ~mask;
        else if (mode == MODE_SET) res = pins | mask;
        else if (mode == MODE_TOGGLE) res = pins ^ mask;
        return res;
    endfunction

    function automatic logic [SPEED_W-1:0] duty_to_percent(input logic [DUTY_W-1:0] duty);
        logic [SPEED_W-1:0] pct;
        if (duty <= 1) pct = '0;
        else if (duty >= DUTY_FULL) pct = SPEED_FULL;
        else pct = SPEED_W'((int'(duty) + 1) / 10);
        return pct;
    endfunction

    // Apply one command or tick to the predicted state, return the expected result
    function automatic t_result step_motors(input logic op, input logic [IN_DATA_W-1:0] word);
        logic [PIN_W-1:0]   mask;
        logic [SPEED_W-1:0] speed;
        int                 limit;
        t_result            res;
        mask = '0;
        speed = word[11:5];
        if (op == OP_COMMAND) begin
            if (int'(word[0]) < MOTOR_COUNT) mask = PIN_W'(1) << word[0];
            en_bits = next_pins(en_bits, word[2:1], mask);
            dir_bits = next_pins(dir_bits, word[4:3], mask);
            // zero speed disables the motor whatever the enable mode said
            if (speed == 0) begin
                en_bits = en_bits & ~mask;
                duty_goal = '0;
            end else if (speed == SPEED_FULL) begin
                duty_goal = DUTY_FULL;
            end else if (speed < SPEED_FULL) begin
                duty_goal = DUTY_W'(int'(speed) * 10 - 1);
            end
        end else begin
            limit = (ramp_len == 0) ? 1 : int'(ramp_len);
            if (duty_now == duty_goal) begin
                tick_cnt = '0;
            end else if (int'(tick_cnt) + 1 >= limit) begin
                tick_cnt = '0;
                if (duty_now < duty_goal) duty_now = duty_now + 1'b1;
                else duty_now = duty_now - 1'b1;
            end else begin
                tick_cnt = tick_cnt + 1'b1;
            end
        end
        res.enable_pins = en_bits;
        res.direction_pins = dir_bits;
        res.duty_compare = duty_now;
        res.ramp_busy = (duty_now != duty_goal);
        res.speed_readback = duty_to_percent(duty_now);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        error_count++;
    endtask

    task automatic push_item(input logic op, input logic motor, input logic [1:0] en_mode,
                             input logic [1:0] dir_mode, input logic [SPEED_W-1:0] speed);
        t_stim_action a;
        a.kind = ACT_ITEM;
        a.op = op;
        a.word = {4'b0, speed, dir_mode, en_mode, motor};
        a.interval = '0;
        stim_q.push_back(a);
    endtask

    task automatic push_tick();
        push_item(OP_TICK, 1'($urandom), 2'($urandom), 2'($urandom), 7'($urandom));
    endtask

    // Register write; the driver holds it until every result is back
    task automatic push_interval(input logic [INTERVAL_W-1:0] val);
        t_stim_action a;
        a.kind = ACT_CFG;
        a.op = OP_COMMAND;
        a.word = '0;
        a.interval = val;
        stim_q.push_back(a);
    endtask

    // Commands with random content, each followed by a run of ticks
    task automatic add_random(input int count, input int top_speed, input int run_max);
        int               added;
        int               run;
        int               pick;
        logic [SPEED_W-1:0] speed;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) speed = '0;
            else if (pick == 1) speed = 7'($urandom_range(101, 127));
            else if (pick == 2) speed = SPEED_FULL;
            else speed = 7'($urandom_range(1, top_speed));
            push_item(OP_COMMAND, 1'($urandom), 2'($urandom), 2'($urandom), speed);
            run = $urandom_range(0, run_max);
            for (int k = 0; k < run; k++) push_tick();
            added += run + 1;
        end
    endtask

    // Monitor: checks results, predicts on every accepted input transaction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycle_cnt++;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[21:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending, duty",
                                    int'(got.duty_compare), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.enable_pins != want.enable_pins)
                        report_mismatch("enable_pins", int'(got.enable_pins),
                                        int'(want.enable_pins));
                    if (got.direction_pins != want.direction_pins)
                        report_mismatch("direction_pins", int'(got.direction_pins),
                                        int'(want.direction_pins));
                    if (got.duty_compare != want.duty_compare)
                        report_mismatch("duty_compare", int'(got.duty_compare),
                                        int'(want.duty_compare));
                    if (got.ramp_busy != want.ramp_busy)
                        report_mismatch("ramp_busy", int'(got.ramp_busy),
                                        int'(want.ramp_busy));
                    if (got.speed_readback != want.speed_readback)
                        report_mismatch("speed_readback", int'(got.speed_readback),
                                        int'(want.speed_readback));
                end
            end
            if (i_cfg_wr_en) ramp_len = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                cmd_taken = 1'b1;
                pending_results.push_back(step_motors(s_axis_tuser, s_axis_tdata));
            end
        end
    end

    // Driver: bursty sender and patterned receiver, updated on the falling edge
    always @(negedge i_clk) begin
        logic                  nxt_valid;
        logic                  nxt_user;
        logic [IN_DATA_W-1:0]  nxt_data;
        logic                  nxt_cfg_en;
        logic [INTERVAL_W-1:0] nxt_cfg_data;
        logic                  nxt_ready;
        t_stim_action          act;
        nxt_valid = s_axis_tvalid && !cmd_taken;
        nxt_user = s_axis_tuser;
        nxt_data = s_axis_tdata;
        nxt_cfg_en = 1'b0;
        nxt_cfg_data = i_cfg_wr_data;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() > 0) begin
                    act = stim_q[0];
                    if (act.kind == ACT_ITEM) begin
                        void'(stim_q.pop_front());
                        nxt_valid = 1'b1;
                        nxt_user = act.op;
                        nxt_data = act.word;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 16);
                            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end else if (pending_results.size() == 0) begin
                        // block is idle: safe to write the interval register
                        void'(stim_q.pop_front());
                        nxt_cfg_en = 1'b1;
                        nxt_cfg_data = act.interval;
                    end
                end else begin
                    stim_done = 1'b1;
                end
            end
            // receiver: always ready, mostly ready, or mostly stalled
            if (ready_span <= 0) begin
                ready_mode = $urandom_range(0, 2);
                ready_span = $urandom_range(8, 64);
            end
            ready_span--;
            if (ready_mode == 0) nxt_ready = 1'b1;
            else if (ready_mode == 1) nxt_ready = ($urandom_range(0, 3) != 0);
            else nxt_ready = ($urandom_range(0, 3) == 0);
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tuser <= nxt_user;
        s_axis_tdata <= nxt_data;
        i_cfg_wr_en <= nxt_cfg_en;
        i_cfg_wr_data <= nxt_cfg_data;
        m_axis_tready <= nxt_ready;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus, reset and end of test
    initial begin
        // directed part at the reset interval: modes, both motors, speed edges
        push_tick();
        push_item(OP_COMMAND, 1'b0, MODE_SET, MODE_SET, SPEED_FULL);
        push_tick();
        push_item(OP_COMMAND, 1'b1, MODE_SET, MODE_CLEAR, 7'd1);
        push_item(OP_COMMAND, 1'b1, MODE_TOGGLE, MODE_TOGGLE, 7'd127);
        push_item(OP_COMMAND, 1'b0, MODE_KEEP, MODE_KEEP, 7'd101);
        push_item(OP_COMMAND, 1'b0, MODE_TOGGLE, MODE_TOGGLE, 7'd99);
        push_item(OP_COMMAND, 1'b1, MODE_CLEAR, MODE_KEEP, 7'd50);
        push_item(OP_COMMAND, 1'b0, MODE_SET, MODE_SET, 7'd0);
        push_tick();
        push_item(OP_COMMAND, 1'b1, MODE_SET, MODE_TOGGLE, 7'd0);
        push_item(OP_COMMAND, 1'b0, MODE_CLEAR, MODE_CLEAR, 7'd127);
        // one step per tick: ramp up to a small target, idle, ramp partway back down
        push_interval(16'd1);
        push_item(OP_COMMAND, 1'b0, MODE_SET, MODE_SET, 7'd1);
        for (int k = 0; k < 11; k++) push_tick();
        push_item(OP_COMMAND, 1'b1, MODE_KEEP, MODE_KEEP, 7'd0);
        for (int k = 0; k < 3; k++) push_tick();
        // random phases across several interval settings
        add_random(120, 5, 40);
        push_interval(16'd0);
        add_random(100, 10, 60);
        push_interval(16'd3);
        add_random(100, 100, 60);
        push_interval(16'hFFFF);
        add_random(40, 100, 20);
        push_interval(16'($urandom_range(2, 9)));
        add_random(100, 3, 40);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_done && pending_results.size() == 0)) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
